// ----- hw/rtl/fbp_pkg.sv -----
// fbp_pkg: shared types and constants for the firmware blob patcher / framer.
// No dependencies; used by fbp_front, fbp_queue, fbp_back and the top level.
package fbp_pkg;

  // hold line (delay line before the framer)
  localparam int LINE_DEPTH = 15;
  localparam int LINE_CW    = 4;   // holds 0..LINE_DEPTH

  // tag 17 record layout, offsets from the record start
  localparam int PATCH_OFS = 12;   // data byte 0
  localparam int BAUD_OFS  = 14;   // data byte 2
  localparam logic [7:0]  TAG_LO     = 8'h11;
  localparam logic [7:0]  RECLEN_LO  = 8'h09;
  localparam logic [7:0]  CLEAR_MASK = 8'h7F;
  localparam logic [24:0] REC_TAIL   = 25'd7;   // record span 21 minus the 14 bytes held before the hit

  // segment header bytes
  localparam logic [7:0] HDR_B0  = 8'h01;
  localparam logic [7:0] HDR_B1  = 8'h00;
  localparam logic [7:0] HDR_B2  = 8'hFC;
  localparam logic [7:0] HDR_B4  = 8'h1E;
  localparam logic [2:0] HDR_LEN = 3'd6;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TOTAL_LENGTH = 2'd0,
    CFG_PATCH_ENABLE = 2'd1,
    CFG_BAUD_CODE    = 2'd2
  } cfg_idx_t;

  // one data byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       file_end;
    logic       run_last;
    logic       found;
  } word_t;

endpackage

// ----- hw/rtl/fbp_front.sv -----
// fbp_front: takes blob bytes, holds them in the 15-byte line, applies the
// tag 17 edit and pushes bytes that can no longer change. Uses fbp_pkg.
module fbp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic [23:0]   total_length,
  input  logic          patch_enable,
  input  logic [7:0]    baud_code,
  input  logic          q_full,
  output logic          push,
  output fbp_pkg::word_t push_word
);

  logic [7:0] line_r   [fbp_pkg::LINE_DEPTH];
  logic [7:0] line_nxt [fbp_pkg::LINE_DEPTH];
  logic [7:0] line_wr  [fbp_pkg::LINE_DEPTH];

  logic [fbp_pkg::LINE_CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [23:0] taken_r, taken_nxt;
  logic        patched_r, patched_nxt;
  logic        flushing_r, flushing_nxt;
  logic        is_last, hit, line_full, flush_end;

  assign in_ready = !flushing_r && !q_full;

  always_comb begin
    line_nxt     = line_r;
    line_wr      = line_r;
    cnt_nxt      = cnt_r;
    taken_nxt    = taken_r;
    patched_nxt  = patched_r;
    flushing_nxt = flushing_r;
    push         = 1'b0;
    push_word    = '0;

    cnt_inc   = cnt_r + 1'b1;
    line_full = (cnt_inc == fbp_pkg::LINE_CW'(fbp_pkg::LINE_DEPTH));
    is_last   = ({1'b0, taken_r} + 25'd1) >= {1'b0, total_length};
    flush_end = (cnt_r == fbp_pkg::LINE_CW'(1));

    for (int i = 0; i < fbp_pkg::LINE_DEPTH; i++) begin
      if (cnt_r == fbp_pkg::LINE_CW'(i)) line_wr[i] = in_byte;
    end

    // record must sit wholly inside the blob
    hit = line_full && patch_enable && !patched_r &&
          (({1'b0, taken_r} + fbp_pkg::REC_TAIL) <= {1'b0, total_length}) &&
          (line_r[0] == fbp_pkg::TAG_LO) && (line_r[1] == 8'h00) &&
          (line_r[2] == fbp_pkg::RECLEN_LO) && (line_r[3] == 8'h00);
    if (hit) begin
      line_wr[fbp_pkg::PATCH_OFS] = line_wr[fbp_pkg::PATCH_OFS] & fbp_pkg::CLEAR_MASK;
      line_wr[fbp_pkg::BAUD_OFS]  = baud_code;
    end

    if (flushing_r) begin
      if (!q_full) begin
        push               = 1'b1;
        push_word.data     = line_r[0];
        push_word.file_end = flush_end;
        push_word.run_last = flush_end;
        push_word.found    = patched_r;
        for (int i = 0; i < fbp_pkg::LINE_DEPTH - 1; i++) line_nxt[i] = line_r[i+1];
        cnt_nxt = cnt_r - 1'b1;
        if (flush_end) begin
          flushing_nxt = 1'b0;
          patched_nxt  = 1'b0;
        end
      end
    end else if (in_valid && in_ready) begin
      if (hit) patched_nxt = 1'b1;
      if (is_last) begin
        line_nxt     = line_wr;
        cnt_nxt      = cnt_inc;
        flushing_nxt = 1'b1;
        taken_nxt    = '0;
      end else begin
        taken_nxt = taken_r + 1'b1;
        if (line_full) begin
          push               = 1'b1;
          push_word.data     = line_wr[0];
          push_word.file_end = 1'b0;
          push_word.run_last = 1'b1;
          push_word.found    = patched_r || hit;
          for (int i = 0; i < fbp_pkg::LINE_DEPTH - 1; i++) line_nxt[i] = line_wr[i+1];
          line_nxt[fbp_pkg::LINE_DEPTH-1] = line_wr[fbp_pkg::LINE_DEPTH-1];
          cnt_nxt = cnt_r;
        end else begin
          line_nxt = line_wr;
          cnt_nxt  = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      taken_r    <= '0;
      patched_r  <= 1'b0;
      flushing_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      taken_r    <= taken_nxt;
      patched_r  <= patched_nxt;
      flushing_r <= flushing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

  // outside a flush the line never holds a full 15 bytes between items
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !flushing_r |-> (cnt_r < fbp_pkg::LINE_CW'(fbp_pkg::LINE_DEPTH)))
    else $error("front: hold count out of range");

endmodule

// ----- hw/rtl/fbp_queue.sv -----
// fbp_queue: short FIFO of byte words between front and back.
// Uses fbp_pkg (word_t, queue sizing).
module fbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fbp_pkg::word_t push_word,
  input  logic           pop,
  output fbp_pkg::word_t head,
  output logic           full,
  output logic           empty
);

  fbp_pkg::word_t mem_r [fbp_pkg::QUEUE_DEPTH];
  logic [fbp_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [fbp_pkg::QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == fbp_pkg::QUEUE_CW'(fbp_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_word;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue: pop while empty");

endmodule

// ----- hw/rtl/fbp_back.sv -----
// fbp_back: frames queued bytes into segments with a six-byte header and
// drives the output register. Uses fbp_pkg.
module fbp_back #(
  parameter int SEGMENT_BYTES = 243
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [23:0]    total_length,
  input  logic           q_empty,
  input  fbp_pkg::word_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_is_header,
  output logic           out_segment_end,
  output logic           out_file_end,
  output logic           out_record_found,
  output logic           out_run_last
);

  logic [7:0]  segpos_r, segpos_nxt;
  logic [23:0] emitted_r, emitted_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        hdr_r, hdr_nxt, seg_end_r, seg_end_nxt, file_end_r, file_end_nxt;
  logic        found_r, found_nxt, run_last_r, run_last_nxt;

  logic        load, need_hdr, seg_end;
  logic [23:0] rem;
  logic [7:0]  seg_n, hdr_byte;

  always_comb begin
    load     = !valid_r || out_ready;
    rem      = (total_length > emitted_r) ? (total_length - emitted_r) : 24'd1;
    seg_n    = (rem < 24'(SEGMENT_BYTES)) ? rem[7:0] : 8'(SEGMENT_BYTES);
    need_hdr = (segpos_r == '0) && (hdr_cnt_r != fbp_pkg::HDR_LEN);
    seg_end  = q_head.file_end || (({1'b0, segpos_r} + 9'd1) >= 9'(SEGMENT_BYTES));

    case (hdr_cnt_r)
      3'd0:    hdr_byte = fbp_pkg::HDR_B0;
      3'd1:    hdr_byte = fbp_pkg::HDR_B1;
      3'd2:    hdr_byte = fbp_pkg::HDR_B2;
      3'd3:    hdr_byte = seg_n + 8'd2;
      3'd4:    hdr_byte = fbp_pkg::HDR_B4;
      3'd5:    hdr_byte = seg_n;
      default: hdr_byte = '0;
    endcase

    valid_nxt    = valid_r;
    byte_nxt     = byte_r;
    hdr_nxt      = hdr_r;
    seg_end_nxt  = seg_end_r;
    file_end_nxt = file_end_r;
    found_nxt    = found_r;
    run_last_nxt = run_last_r;
    segpos_nxt   = segpos_r;
    emitted_nxt  = emitted_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    q_pop        = 1'b0;

    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        found_nxt = q_head.found;
        if (need_hdr) begin
          byte_nxt     = hdr_byte;
          hdr_nxt      = 1'b1;
          seg_end_nxt  = 1'b0;
          file_end_nxt = 1'b0;
          run_last_nxt = 1'b0;
          hdr_cnt_nxt  = hdr_cnt_r + 1'b1;
        end else begin
          q_pop        = 1'b1;
          byte_nxt     = q_head.data;
          hdr_nxt      = 1'b0;
          seg_end_nxt  = seg_end;
          file_end_nxt = q_head.file_end;
          run_last_nxt = q_head.run_last;
          hdr_cnt_nxt  = '0;
          segpos_nxt   = seg_end ? '0 : segpos_r + 1'b1;
          emitted_nxt  = q_head.file_end ? '0 : emitted_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      segpos_r  <= '0;
      emitted_r <= '0;
      hdr_cnt_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      segpos_r  <= segpos_nxt;
      emitted_r <= emitted_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    hdr_r      <= hdr_nxt;
    seg_end_r  <= seg_end_nxt;
    file_end_r <= file_end_nxt;
    found_r    <= found_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_is_header    = hdr_r;
  assign out_segment_end  = seg_end_r;
  assign out_file_end     = file_end_r;
  assign out_record_found = found_r;
  assign out_run_last     = run_last_r;

  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= fbp_pkg::HDR_LEN)
    else $error("back: header counter overran");

  a_file_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && file_end_r) |-> (run_last_r && seg_end_r && !hdr_r))
    else $error("back: file end word not closing its run");

endmodule

// ----- hw/rtl/fw_blob_patch_and_hci_framer.sv -----
// fw_blob_patch_and_hci_framer: top level of the blob patcher and HCI framer.
// Instantiates fbp_front, fbp_queue and fbp_back; uses fbp_pkg.
//
// Takes a firmware blob one byte per input word and emits a framed HCI
// command stream, one byte per output word. The front holds the last 15
// bytes in a delay line; with patching on it finds the first tag 17 /
// length 9 record lying wholly inside the blob, clears bit 7 of its data
// byte 0 and writes baud_code into data byte 2. Bytes leave the line once
// they can no longer change and pass through a 4-word queue to the back,
// which cuts them into segments of SEGMENT_BYTES (or the shorter remainder)
// behind the header 01 00 FC n+2 1E n. Rate: in steady flow one input word
// is taken per cycle, unless the queue is full or a flush is running; the
// back sends the six header bytes of each segment before its data bytes
// and pops no queue word meanwhile. The first 14 bytes of a blob produce no output.
// The final byte of a blob starts a flush: the front then takes no input
// until every held byte (up to 15) has gone into the queue, as the output side drains it.
// Configuration: cfg_ready is always high; index 0 total_length,
// 1 patch_enable, 2 baud_code; other indexes are ignored. Write only while
// the block is idle.
module fw_blob_patch_and_hci_framer #(
  parameter int SEGMENT_BYTES = 243
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // blob byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // framed stream output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_header,
  output logic        out_segment_end,
  output logic        out_file_end,
  output logic        out_record_found,
  output logic        out_run_last
);

  // configuration registers
  logic [23:0] total_length_r;
  logic        patch_enable_r;
  logic [7:0]  baud_code_r;

  // front/queue/back links
  logic           push, pop, q_full, q_empty;
  fbp_pkg::word_t push_word, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= 24'd1;
      patch_enable_r <= 1'b0;
      baud_code_r    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbp_pkg::CFG_TOTAL_LENGTH: total_length_r <= cfg_data;
        fbp_pkg::CFG_PATCH_ENABLE: patch_enable_r <= cfg_data[0];
        fbp_pkg::CFG_BAUD_CODE:    baud_code_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: delay line, record search and patch, flush at end of blob
  fbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .total_length (total_length_r),
    .patch_enable (patch_enable_r),
    .baud_code    (baud_code_r),
    .q_full       (q_full),
    .push         (push),
    .push_word    (push_word)
  );

  // queue: lets the front keep taking bytes while a header goes out
  fbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: segment headers, end marks, output register
  fbp_back #(
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .total_length     (total_length_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_is_header    (out_is_header),
    .out_segment_end  (out_segment_end),
    .out_file_end     (out_file_end),
    .out_record_found (out_record_found),
    .out_run_last     (out_run_last)
  );

endmodule
